/* design/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and codes for the first-fit heap allocator: descriptor word,
// stack operations, sequencer states, request kinds and status codes.
// ----------------------------------------------------------------------------
package ffha_pkg;

  // one block descriptor: header offset, payload size, free mark
  typedef struct packed {
    logic [15:0] off;
    logic [15:0] size;
    logic        free;
  } desc_t;

  // operation applied to every cell of a chain in the same cycle
  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP,
    STK_LOAD
  } stk_op_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_REWIND,
    S_FIND,
    S_FIT,
    S_GROW,
    S_PLACE,
    S_MERGE,
    S_RESULT
  } state_e;

  // what the request still has to do after a lookup
  typedef enum logic [1:0] {
    J_FREE,
    J_REALLOC,
    J_MOVE
  } job_e;

  // request kinds
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FREE    = 2'd1;
  localparam logic [1:0] KIND_REALLOC = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_ZERO      = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;

endpackage

/* design/ffha_cell.sv */
// ----------------------------------------------------------------------------
// ffha_cell
// One descriptor cell of a stack chain. Takes its upper neighbor on push,
// its lower neighbor on pop; the top cell also takes new data on load.
// ----------------------------------------------------------------------------
module ffha_cell #(
  parameter bit IS_TOP = 1'b0
) (
  input  logic             clk_i,
  input  ffha_pkg::stk_op_e op_i,
  input  ffha_pkg::desc_t  up_i,
  input  ffha_pkg::desc_t  down_i,
  output ffha_pkg::desc_t  q_o
);
  import ffha_pkg::*;

  desc_t cell_d, cell_q;

  // neighbor select
  always_comb begin
    unique case (op_i)
      STK_HOLD: cell_d = cell_q;
      STK_PUSH: cell_d = up_i;
      STK_POP:  cell_d = down_i;
      STK_LOAD: cell_d = IS_TOP ? up_i : cell_q;
    endcase
  end

  // descriptor storage, no reset
  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign q_o = cell_q;

endmodule

/* design/ffha_stack.sv */
// ----------------------------------------------------------------------------
// ffha_stack
// A chain of descriptor cells used as a stack: push or pop, every cell
// shifting to its neighbor in the same cycle, or load the top. Keeps its fill.
// ----------------------------------------------------------------------------
module ffha_stack #(
  parameter int DEPTH = 2048,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ffha_pkg::stk_op_e op_i,
  input  ffha_pkg::desc_t   data_i,
  output ffha_pkg::desc_t   top_o,
  output logic [CW-1:0]     count_o
);
  import ffha_pkg::*;

  desc_t         cell_q [DEPTH];
  logic [CW-1:0] count_d, count_q;

  // row of cells
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    desc_t up, down;
    if (k == 0) begin : g_first
      assign up = data_i;
    end else begin : g_mid
      assign up = cell_q[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign down = cell_q[k];
    end else begin : g_inner
      assign down = cell_q[k+1];
    end
    ffha_cell #(
      .IS_TOP (k == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (op_i),
      .up_i   (up),
      .down_i (down),
      .q_o    (cell_q[k])
    );
  end

  // fill count
  always_comb begin
    unique case (op_i)
      STK_PUSH: count_d = count_q + CW'(1);
      STK_POP:  count_d = count_q - CW'(1);
      STK_HOLD,
      STK_LOAD: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign top_o   = cell_q[0];
  assign count_o = count_q;

endmodule

/* design/first_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a fixed byte pool with split and coalesce.
// ----------------------------------------------------------------------------
// The descriptor list lives in two chains of cells that meet at a cursor; the
// cursor moves one descriptor per cycle while it walks, so the time a request
// takes is set by walks over the list: every lookup, search or merge first
// rewinds the cursor to the list head and then walks the list. An allocate
// that finds no free block first appends a page-rounded region at the pool
// top; a moving reallocate looks up, searches, places, then frees the old
// block and merges. The result word is shown for exactly one cycle with
// done_o, and busy stays high until that cycle is over; the receiver cannot
// stall it. There is no clearing pass.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int POOL_BYTES   = 65536,
  parameter int PAGE_BYTES   = 4096,
  parameter int HEADER_BYTES = 24,
  parameter int MAX_BLOCKS   = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [15:0] request_bytes_i,
  input  logic [15:0] payload_address_i,
  output logic        done_o,
  output logic [15:0] result_address_o,
  output logic [15:0] copy_bytes_o,
  output logic [1:0]  status_o
);
  import ffha_pkg::*;

  localparam int          CW   = $clog2(MAX_BLOCKS + 1);
  localparam logic [17:0] HDR  = 18'(HEADER_BYTES);
  localparam logic [17:0] PAGE = 18'(PAGE_BYTES);
  localparam logic [18:0] POOL = 19'(POOL_BYTES);

  state_e        state_d, state_q;
  state_e        phase_d, phase_q;
  job_e          job_d, job_q;
  logic [15:0]   bytes_d, bytes_q;
  logic [15:0]   addr_d, addr_q;
  logic [16:0]   need_d, need_q;
  logic [15:0]   old_d, old_q;
  logic [17:0]   region_d, region_q;
  logic [16:0]   top_d, top_q;
  logic [15:0]   res_d, res_q;
  logic [15:0]   copy_d, copy_q;
  logic [1:0]    st_d, st_q;

  stk_op_e       l_op, r_op;
  desc_t         l_data, r_data;
  desc_t         prv, cur;
  logic [CW-1:0] l_cnt, r_cnt, blk_cnt;

  logic [16:0]   need_in;
  logic          lempty, rempty;
  logic          addr_match, fit_hit, grow_more, exhaust, mergeable, split_ok;
  logic [17:0]   req, prv_end;

  // left chain: descriptors before the cursor, top is the nearest
  ffha_stack #(
    .DEPTH (MAX_BLOCKS),
    .CW    (CW)
  ) u_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (l_op),
    .data_i  (l_data),
    .top_o   (prv),
    .count_o (l_cnt)
  );

  // right chain: descriptors from the cursor on, top is the current one
  ffha_stack #(
    .DEPTH (MAX_BLOCKS),
    .CW    (CW)
  ) u_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (r_op),
    .data_i  (r_data),
    .top_o   (cur),
    .count_o (r_cnt)
  );

  // shared conditions
  assign blk_cnt    = l_cnt + r_cnt;
  assign lempty     = (l_cnt == '0);
  assign rempty     = (r_cnt == '0);
  assign need_in    = ({1'b0, request_bytes_i} + 17'd7) & ~17'd7;
  assign req        = {1'b0, need_q} + HDR;
  assign prv_end    = {2'b0, prv.off} + HDR + {2'b0, prv.size};
  assign addr_match = !rempty && ({2'b0, cur.off} + HDR == {2'b0, addr_q});
  assign fit_hit    = !rempty && cur.free && ({1'b0, cur.size} >= need_q);
  assign grow_more  = (region_q < req);
  assign exhaust    = (blk_cnt >= CW'(MAX_BLOCKS))
                   || ({2'b0, top_q} + {1'b0, region_q} > POOL);
  assign mergeable  = !lempty && !rempty && prv.free && cur.free
                   && (prv_end == {2'b0, cur.off});
  assign split_ok   = ({2'b0, cur.size} > req + 18'd8)
                   && (blk_cnt < CW'(MAX_BLOCKS));

  // next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (kind_i)
            KIND_ALLOC: begin
              state_d = (need_in == '0) ? S_RESULT : S_REWIND;
              phase_d = S_FIT;
            end
            KIND_FREE: begin
              state_d = (payload_address_i == '0) ? S_RESULT : S_REWIND;
              phase_d = S_FIND;
            end
            KIND_REALLOC: begin
              if (payload_address_i != '0) begin
                state_d = S_REWIND;
                phase_d = S_FIND;
              end else begin
                state_d = (need_in == '0) ? S_RESULT : S_REWIND;
                phase_d = S_FIT;
              end
            end
            default: state_d = S_RESULT;
          endcase
        end
      end
      S_REWIND: begin
        if (lempty) state_d = phase_q;
      end
      S_FIND: begin
        if (addr_match) begin
          if (job_q != J_REALLOC || bytes_q == '0) begin
            state_d = S_REWIND;
            phase_d = S_MERGE;
          end else if (cur.size >= bytes_q) begin
            state_d = S_RESULT;
          end else begin
            state_d = S_REWIND;
            phase_d = S_FIT;
          end
        end else if (rempty) begin
          if (job_q != J_REALLOC || need_q == '0) begin
            state_d = S_RESULT;
          end else begin
            state_d = S_REWIND;
            phase_d = S_FIT;
          end
        end
      end
      S_FIT: begin
        if (rempty) state_d = S_GROW;
        else if (fit_hit) state_d = S_PLACE;
      end
      S_GROW: begin
        if (!grow_more) state_d = exhaust ? S_RESULT : S_PLACE;
      end
      S_PLACE: begin
        if (job_q == J_MOVE) begin
          state_d = S_REWIND;
          phase_d = S_FIND;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_MERGE: begin
        if (rempty) state_d = S_RESULT;
      end
      S_RESULT: state_d = S_IDLE;
    endcase
  end

  // datapath and chain control
  always_comb begin
    l_op     = STK_HOLD;
    r_op     = STK_HOLD;
    l_data   = cur;
    r_data   = prv;
    job_d    = job_q;
    bytes_d  = bytes_q;
    addr_d   = addr_q;
    need_d   = need_q;
    old_d    = old_q;
    region_d = region_q;
    top_d    = top_q;
    res_d    = res_q;
    copy_d   = copy_q;
    st_d     = st_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          bytes_d = request_bytes_i;
          addr_d  = payload_address_i;
          need_d  = need_in;
          res_d   = '0;
          copy_d  = '0;
          st_d    = ST_DONE;
          job_d   = (kind_i == KIND_FREE) ? J_FREE : J_REALLOC;
          if (need_in == '0 && (kind_i == KIND_ALLOC
              || (kind_i == KIND_REALLOC && payload_address_i == '0))) begin
            st_d = ST_ZERO;
          end
        end
      end
      // cursor back to the list head
      S_REWIND: begin
        if (!lempty) begin
          l_op = STK_POP;
          r_op = STK_PUSH;
        end
      end
      // payload address lookup
      S_FIND: begin
        if (addr_match) begin
          if (job_q != J_REALLOC || bytes_q == '0) begin
            r_op        = STK_LOAD;
            r_data      = cur;
            r_data.free = 1'b1;
            if (job_q == J_REALLOC) st_d = ST_ZERO;
          end else if (cur.size >= bytes_q) begin
            res_d = addr_q;
          end else begin
            old_d = cur.size;
            job_d = J_MOVE;
          end
        end else if (rempty) begin
          if (job_q == J_REALLOC && need_q == '0) st_d = ST_ZERO;
        end else begin
          l_op = STK_PUSH;
          r_op = STK_POP;
        end
      end
      // first-fit search
      S_FIT: begin
        if (rempty) begin
          region_d = '0;
        end else if (!fit_hit) begin
          l_op = STK_PUSH;
          r_op = STK_POP;
        end
      end
      // page-rounded region at the pool top
      S_GROW: begin
        if (grow_more) begin
          region_d = region_q + PAGE;
        end else if (exhaust) begin
          st_d = ST_EXHAUSTED;
        end else begin
          r_op        = STK_PUSH;
          r_data.off  = top_q[15:0];
          r_data.size = 16'(region_q - HDR);
          r_data.free = 1'b1;
          top_d       = top_q + region_q[16:0];
        end
      end
      // grant the picked block, split off the tail when large
      S_PLACE: begin
        if (split_ok) begin
          l_op        = STK_PUSH;
          l_data.off  = cur.off;
          l_data.size = need_q[15:0];
          l_data.free = 1'b0;
          r_op        = STK_LOAD;
          r_data.off  = 16'({2'b0, cur.off} + req);
          r_data.size = 16'({2'b0, cur.size} - req);
          r_data.free = 1'b1;
        end else begin
          r_op        = STK_LOAD;
          r_data      = cur;
          r_data.free = 1'b0;
        end
        res_d = 16'({2'b0, cur.off} + HDR);
        if (job_q == J_MOVE) begin
          copy_d = old_q;
          job_d  = J_FREE;
        end
      end
      // coalesce adjacent free blocks
      S_MERGE: begin
        if (!rempty) begin
          if (mergeable) begin
            l_op        = STK_LOAD;
            l_data      = prv;
            l_data.size = 16'(prv_end - {2'b0, prv.off} + {2'b0, cur.size});
            r_op        = STK_POP;
          end else begin
            l_op = STK_PUSH;
            r_op = STK_POP;
          end
        end
      end
      S_RESULT: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= S_IDLE;
      job_q   <= J_FREE;
      top_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      job_q   <= job_d;
      top_q   <= top_d;
    end
  end

  // request and result word
  always_ff @(posedge clk_i) begin
    bytes_q  <= bytes_d;
    addr_q   <= addr_d;
    need_q   <= need_d;
    old_q    <= old_d;
    region_q <= region_d;
    res_q    <= res_d;
    copy_q   <= copy_d;
    st_q     <= st_d;
  end

  assign busy             = (state_q != S_IDLE);
  assign done_o           = (state_q == S_RESULT);
  assign result_address_o = res_q;
  assign copy_bytes_o     = copy_q;
  assign status_o         = st_q;

`ifndef SYNTH
  // the two chains together never hold more than the list size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, l_cnt} + {1'b0, r_cnt} <= (CW + 1)'(MAX_BLOCKS)))
    else $error("descriptor count above list size");

  // handed-out pool never passes the pool size
  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({2'b0, top_q} <= POOL))
    else $error("pool top above pool size");

  // a result word is followed by an idle block
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("busy after result word");

  // status is one of the three codes
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_DONE || status_o == ST_ZERO
                || status_o == ST_EXHAUSTED))
    else $error("bad status code");

  // a free request never grants an address
  a_free_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == KIND_FREE) |=> (res_q == '0))
    else $error("free request granted an address");
`endif

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit heap allocator: directed requests
// for corner cases, then random alloc/free/realloc traffic; a scoreboard
// predicts every result word from its own copy of the descriptor list.
// ----------------------------------------------------------------------------
import ffha_pkg::*;

class heap_scoreboard;
  localparam int unsigned POOL  = 65536;
  localparam int unsigned PAGE  = 4096;
  localparam int unsigned HDR   = 24;
  localparam int unsigned SLOTS = 2048;

  typedef struct {
    logic [15:0] addr;
    logic [15:0] copy;
    logic [1:0]  status;
  } heap_word_t;

  // predicted descriptor list
  logic [15:0] offs [SLOTS];
  logic [15:0] sizes [SLOTS];
  bit          frees [SLOTS];
  int unsigned count;
  int unsigned top;

  heap_word_t  expected_words[$];
  int          fails;

  function int find_payload(int unsigned addr);
    for (int unsigned i = 0; i < count; i++)
      if (offs[i] + HDR == addr) return i;
    return -1;
  endfunction

  function void drop_slot(int unsigned pos);
    for (int unsigned i = pos; i + 1 < count; i++) begin
      offs[i] = offs[i+1]; sizes[i] = sizes[i+1]; frees[i] = frees[i+1];
    end
    count--;
  endfunction

  function void coalesce();
    int unsigned i;
    i = 0;
    while (i + 1 < count) begin
      if (frees[i] && frees[i+1] && offs[i] + HDR + sizes[i] == offs[i+1]) begin
        sizes[i] = 16'(sizes[i] + HDR + sizes[i+1]);
        drop_slot(i + 1);
      end else begin
        i++;
      end
    end
  endfunction

  function void release_block(int unsigned addr);
    int idx;
    if (addr == 0) return;
    idx = find_payload(addr);
    if (idx < 0) return;
    frees[idx] = 1;
    coalesce();
  endfunction

  // first fit, else grow from the pool top, then split off the tail
  function int unsigned grant(int unsigned bytes, output logic [1:0] st);
    int unsigned need, pick, region;
    bit hit;
    need = (bytes + 7) & ~32'd7;
    st = ST_DONE;
    hit = 0;
    pick = 0;
    if (need == 0) begin
      st = ST_ZERO;
      return 0;
    end
    for (int unsigned i = 0; i < count; i++)
      if (!hit && frees[i] && sizes[i] >= need) begin
        pick = i; hit = 1;
      end
    if (!hit) begin
      region = ((HDR + need + PAGE - 1) / PAGE) * PAGE;
      if (count >= SLOTS || region > POOL || top > POOL - region) begin
        st = ST_EXHAUSTED;
        return 0;
      end
      pick = count;
      offs[pick] = 16'(top);
      sizes[pick] = 16'(region - HDR);
      frees[pick] = 1;
      count++;
      top += region;
    end
    if (sizes[pick] > need + HDR + 8 && count < SLOTS) begin
      for (int unsigned j = count; j > pick + 1; j--) begin
        offs[j] = offs[j-1]; sizes[j] = sizes[j-1]; frees[j] = frees[j-1];
      end
      offs[pick+1] = 16'(offs[pick] + HDR + need);
      sizes[pick+1] = 16'(sizes[pick] - need - HDR);
      frees[pick+1] = 1;
      count++;
      sizes[pick] = 16'(need);
    end
    frees[pick] = 0;
    return (offs[pick] + HDR) & 16'hffff;
  endfunction

  // accepted request: predict its result word
  function void note(logic [1:0] kind, logic [15:0] bytes, logic [15:0] addr);
    heap_word_t w;
    int idx;
    int unsigned old;
    w.addr = 0; w.copy = 0; w.status = ST_DONE;
    if (kind == KIND_ALLOC) begin
      w.addr = 16'(grant(bytes, w.status));
    end else if (kind == KIND_FREE) begin
      release_block(addr);
    end else if (kind == KIND_REALLOC) begin
      idx = (addr != 0) ? find_payload(addr) : -1;
      if (idx < 0) begin
        w.addr = 16'(grant(bytes, w.status));
      end else if (bytes == 0) begin
        release_block(addr);
        w.status = ST_ZERO;
      end else if (sizes[idx] >= bytes) begin
        w.addr = addr;
      end else begin
        old = sizes[idx];
        w.addr = 16'(grant(bytes, w.status));
        if (w.addr != 0) begin
          w.copy = 16'(old);
          release_block(addr);
        end
      end
    end
    expected_words.push_back(w);
  endfunction

  function void check(logic [15:0] addr, logic [15:0] copy, logic [1:0] status);
    heap_word_t w;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected word addr=%h copy=%h status=%0d", $time, addr, copy, status);
      fails++;
      return;
    end
    w = expected_words.pop_front();
    if (addr !== w.addr) begin
      $display("%0t: result_address expected %h actual %h", $time, w.addr, addr);
      fails++;
    end
    if (copy !== w.copy) begin
      $display("%0t: copy_bytes expected %h actual %h", $time, w.copy, copy);
      fails++;
    end
    if (status !== w.status) begin
      $display("%0t: status expected %0d actual %0d", $time, w.status, status);
      fails++;
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 100000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  kind_i = KIND_ALLOC;
  logic [15:0] request_bytes_i = 0;
  logic [15:0] payload_address_i = 0;
  logic        done_o;
  logic [15:0] result_address_o;
  logic [15:0] copy_bytes_o;
  logic [1:0]  status_o;

  heap_scoreboard sb = new();
  logic [15:0] granted[$];
  bit          gaps_on = 1;
  int          quiet_cycles = 0;

  first_fit_heap_allocator dut (.*);

  initial forever #10 clk_i = ~clk_i;

  // accept and check on the rising edge
  always @(posedge clk_i) begin : b_mon
    bit seen;
    seen = 0;
    if (rst_ni) begin
      if (start && !busy) begin
        sb.note(kind_i, request_bytes_i, payload_address_i);
        seen = 1;
      end
      if (done_o) begin
        sb.check(result_address_o, copy_bytes_o, status_o);
        if (result_address_o != 0) granted.push_back(result_address_o);
        if (granted.size() > 64) void'(granted.pop_front());
        seen = 1;
      end
      quiet_cycles <= seen ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // send one request word; start stays high straight into the next word
  task automatic send(logic [1:0] kind, logic [15:0] bytes, logic [15:0] addr);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start = 1;
    kind_i = kind;
    request_bytes_i = bytes;
    payload_address_i = addr;
    while (busy) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_live();
    if (granted.size() == 0) return 16'($urandom_range(1, 65535));
    return granted[$urandom_range(0, granted.size() - 1)];
  endfunction

  // wait until all words are back so addresses are known
  task automatic drain();
    start = 0;
    while (sb.expected_words.size() != 0) @(negedge clk_i);
  endtask

  task automatic random_request();
    int r;
    logic [15:0] bytes;
    r = $urandom_range(0, 99);
    bytes = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
    if (r < 40) send(KIND_ALLOC, bytes, 16'($urandom));
    else if (r < 70) send(KIND_FREE, 0, ($urandom_range(0, 9) == 0) ? 16'($urandom) : pick_live());
    else if (r < 95)
      send(KIND_REALLOC, bytes, ($urandom_range(0, 9) == 0) ? 16'($urandom) : pick_live());
    else send(KIND_UNUSED, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed corners
    send(KIND_ALLOC, 0, 0);
    send(KIND_ALLOC, 16'hffff, 16'hffff);
    send(KIND_ALLOC, 1, 0);
    send(KIND_ALLOC, 8, 0);
    send(KIND_ALLOC, 4072, 0);
    send(KIND_ALLOC, 100, 0);
    drain();
    send(KIND_FREE, 0, 0);
    send(KIND_FREE, 0, 16'd5);
    send(KIND_FREE, 0, granted[1]);
    send(KIND_FREE, 0, granted[1]);
    send(KIND_REALLOC, 16, granted[1]);
    send(KIND_REALLOC, 40, 0);
    send(KIND_REALLOC, 64, 16'd7);
    send(KIND_REALLOC, 4, granted[0]);
    send(KIND_REALLOC, 900, granted[0]);
    drain();
    send(KIND_REALLOC, 16'hfff0, granted[granted.size()-1]);
    send(KIND_REALLOC, 0, granted[granted.size()-1]);
    send(KIND_UNUSED, 16'hffff, 16'hffff);
    send(KIND_ALLOC, 40000, 0);
    send(KIND_ALLOC, 30000, 0);
    drain();

    // random traffic, tail without gaps
    for (int n = 0; n < 120; n++) begin
      if (n == 100) gaps_on = 0;
      if ($urandom_range(0, 4) == 0) drain();
      random_request();
    end
    drain();
    repeat (50) @(negedge clk_i);
    if (sb.fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
